@@ rtl/rvg_pkg.sv @@
`timescale 1ns / 1ps

package rvg_pkg;

	localparam int COORD_W    = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int R2_W       = 19;
	localparam int ROOT_W     = 18;
	localparam int SQ_W       = 22;
	localparam int GAIN_W     = 16;
	localparam int COEF_W     = 16;

	localparam int SQRT_STEPS  = 3;
	localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam logic [R2_W-1:0] R2_MAX = '1;
	localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sh1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_INV_RADIUS_SQ,
		REG_COEF_ROOT,
		REG_COEF_LINEAR,
		REG_COEF_SQUARE
	} reg_index_t;

	typedef struct packed {
		logic [15:0]               center_x;
		logic [15:0]               center_y;
		logic [31:0]               inv_radius_sq;
		logic signed [COEF_W-1:0]  coef_root;
		logic signed [COEF_W-1:0]  coef_linear;
		logic signed [COEF_W-1:0]  coef_square;
	} cfg_t;

	typedef struct packed {
		logic [R2_W-1:0] r2;
		logic            sat;
	} radius_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic [R2_W-1:0]   r2;
		logic [SQ_W-1:0]   sq;
		logic              sat;
	} terms_t;

endpackage

@@ rtl/rvg_radius.sv @@
`timescale 1ns / 1ps

module rvg_radius #(
	parameter int MAX_WIDTH  = rvg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rvg_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rvg_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rvg_pkg::COORD_W-1:0]  column,
	input  logic [rvg_pkg::COORD_W-1:0]  row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rvg_pkg::radius_t             out_data
);
	import rvg_pkg::*;

	localparam logic [COORD_W-1:0] COL_LIM = COORD_W'(MAX_WIDTH - 1);
	localparam logic [COORD_W-1:0] ROW_LIM = COORD_W'(MAX_HEIGHT - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [16:0] dx_s1, dy_s1;
	logic [32:0]        d2_s2;
	logic [48:0]        phi_s3, plo_s3;
	radius_t            r_s4;

	logic [COORD_W-1:0] col_c, row_c;
	logic signed [17:0] dx_w, dy_w;
	logic signed [33:0] sqx_w, sqy_w;
	logic [32:0]        d2_w;
	logic [48:0]        sum_w;
	logic [32:0]        r2_full;
	radius_t            r_w;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		col_c = (column > COL_LIM) ? COL_LIM : column;
		row_c = (row > ROW_LIM) ? ROW_LIM : row;
		dx_w = $signed({2'b00, col_c, 4'b0000}) - $signed({2'b00, cfg.center_x});
		dy_w = $signed({2'b00, row_c, 4'b0000}) - $signed({2'b00, cfg.center_y});
		sqx_w = dx_s1 * dx_s1;
		sqy_w = dy_s1 * dy_s1;
		d2_w = 33'(sqx_w[31:0]) + 33'(sqy_w[31:0]);
		sum_w = phi_s3 + {16'b0, plo_s3[48:16]};
		r2_full = sum_w[48:16];
		r_w.sat = |r2_full[32:R2_W];
		r_w.r2 = r_w.sat ? R2_MAX : r2_full[R2_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dx_s1 <= dx_w[16:0];
			dy_s1 <= dy_w[16:0];
		end
		if (rdy2 && v_s1) d2_s2 <= d2_w;
		if (rdy3 && v_s2) begin
			phi_s3 <= {16'b0, d2_s2} * {33'b0, cfg.inv_radius_sq[31:16]};
			plo_s3 <= {16'b0, d2_s2} * {33'b0, cfg.inv_radius_sq[15:0]};
		end
		if (rdy4 && v_s3) r_s4 <= r_w;
	end

	assign out_valid = v_s4;
	assign out_data  = r_s4;

endmodule

@@ rtl/rvg_sqrt.sv @@
`timescale 1ns / 1ps

module rvg_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rvg_pkg::radius_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rvg_pkg::terms_t   out_data
);
	import rvg_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int RAD_W = 2 * ROOT_W;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sqrt_t;

	typedef struct packed {
		logic [R2_W-1:0] r2;
		logic [SQ_W-1:0] sq;
		logic            sat;
	} side_t;

	function automatic sqrt_t sqrt_step(sqrt_t s);
		logic [REM_W+1:0] rem_x;
		logic [REM_W+1:0] trial;
		sqrt_t            n;
		rem_x = {s.rem, s.rad[RAD_W-1 -: 2]};
		trial = {2'b00, s.root, 2'b01};
		n.rad = {s.rad[RAD_W-3:0], 2'b00};
		if (rem_x >= trial) begin
			n.rem  = REM_W'(rem_x - trial);
			n.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = rem_x[REM_W-1:0];
			n.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	function automatic sqrt_t sqrt_stage(sqrt_t s);
		sqrt_t t;
		t = s;
		for (int i = 0; i < SQRT_STEPS; i++) begin
			t = sqrt_step(t);
		end
		return t;
	endfunction

	logic  v_s   [SQRT_STAGES];
	logic  rdy   [SQRT_STAGES];
	sqrt_t sq_s  [SQRT_STAGES];
	side_t side_s[SQRT_STAGES];
	sqrt_t nxt   [SQRT_STAGES];

	sqrt_t             init_w;
	side_t             side_w;
	logic [2*R2_W-1:0] prod_w;

	always_comb begin
		init_w.rem  = '0;
		init_w.root = '0;
		init_w.rad  = RAD_W'({in_data.r2, 16'b0});
		prod_w      = {{R2_W{1'b0}}, in_data.r2} * {{R2_W{1'b0}}, in_data.r2};
		side_w.r2   = in_data.r2;
		side_w.sq   = prod_w[16 +: SQ_W];
		side_w.sat  = in_data.sat;
		for (int k = 0; k < SQRT_STAGES; k++) begin
			nxt[k] = sqrt_stage((k == 0) ? init_w : sq_s[(k == 0) ? 0 : k - 1]);
		end
		rdy[SQRT_STAGES-1] = !v_s[SQRT_STAGES-1] || out_ready;
		for (int k = SQRT_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQRT_STAGES; k++) v_s[k] <= 1'b0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			sq_s[0]   <= nxt[0];
			side_s[0] <= side_w;
		end
		for (int k = 1; k < SQRT_STAGES; k++) begin
			if (rdy[k] && v_s[k-1]) begin
				sq_s[k]   <= nxt[k];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid     = v_s[SQRT_STAGES-1];
	assign out_data.root = sq_s[SQRT_STAGES-1].root;
	assign out_data.r2   = side_s[SQRT_STAGES-1].r2;
	assign out_data.sq   = side_s[SQRT_STAGES-1].sq;
	assign out_data.sat  = side_s[SQRT_STAGES-1].sat;

endmodule

@@ rtl/rvg_poly.sv @@
`timescale 1ns / 1ps

module rvg_poly (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rvg_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rvg_pkg::terms_t                   in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [rvg_pkg::GAIN_W-1:0] gain,
	output logic                              saturated
);
	import rvg_pkg::*;

	localparam int ACC_W = 40;
	localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(64'sd1 <<< 28);
	localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd1 <<< 15);
	localparam logic signed [23:0] G_HI = 24'sd32767;
	localparam logic signed [23:0] G_LO = -24'sd32768;

	logic v_p1, v_p2, v_p3;
	logic rdy1, rdy2, rdy3;

	logic signed [34:0]       ma_p1;
	logic signed [35:0]       mb_p1;
	logic signed [38:0]       mc_p1;
	logic                     sat_p1, sat_p2, sat_p3;
	logic signed [ACC_W-1:0]  acc_p2;
	logic signed [GAIN_W-1:0] gain_p3;

	logic signed [34:0]       ma_w;
	logic signed [35:0]       mb_w;
	logic signed [38:0]       mc_w;
	logic signed [ACC_W-1:0]  acc_w;
	logic signed [ACC_W-1:0]  rnd_w;
	logic signed [23:0]       g_w;
	logic signed [GAIN_W-1:0] gain_w;
	logic                     sat_w;
	logic                     coef_zero;

	assign rdy3 = !v_p3 || out_ready;
	assign rdy2 = !v_p2 || rdy3;
	assign rdy1 = !v_p1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		ma_w  = cfg.coef_root * $signed({1'b0, in_data.root});
		mb_w  = cfg.coef_linear * $signed({1'b0, in_data.r2});
		mc_w  = cfg.coef_square * $signed({1'b0, in_data.sq});
		acc_w = ACC_ONE + ACC_W'(ma_p1) + ACC_W'(mb_p1) + ACC_W'(mc_p1);
		rnd_w = acc_p2 + ACC_HALF;
		g_w   = rnd_w[39:16];
		coef_zero = (cfg.coef_root == '0) && (cfg.coef_linear == '0) &&
			(cfg.coef_square == '0);
		sat_w  = sat_p2;
		gain_w = g_w[GAIN_W-1:0];
		if (g_w > G_HI) begin
			gain_w = 16'sh7FFF;
			sat_w  = 1'b1;
		end else if (g_w < G_LO) begin
			gain_w = 16'sh8000;
			sat_w  = 1'b1;
		end
		if (coef_zero) begin
			gain_w = GAIN_ONE;
			sat_w  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else begin
			if (rdy1) v_p1 <= in_valid;
			if (rdy2) v_p2 <= v_p1;
			if (rdy3) v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			ma_p1  <= ma_w;
			mb_p1  <= mb_w;
			mc_p1  <= mc_w;
			sat_p1 <= in_data.sat;
		end
		if (rdy2 && v_p1) begin
			acc_p2 <= acc_w;
			sat_p2 <= sat_p1;
		end
		if (rdy3 && v_p2) begin
			gain_p3 <= gain_w;
			sat_p3  <= sat_w;
		end
	end

	assign out_valid = v_p3;
	assign gain      = gain_p3;
	assign saturated = sat_p3;

endmodule

@@ rtl/radial_vignette_gain_top.sv @@
`timescale 1ns / 1ps

// Computes a lens-shading gain for each pixel coordinate: the squared distance
// to the optical centre is scaled by the inverse square of the maximum radius
// into a Q3.16 value r2, and the gain 1 + a*sqrt(r2) + b*r2 + c*r2^2 is returned
// in signed Q4.12 with a flag when r2 or the gain was clipped; with all three
// coefficients zero the gain is one and the flag clear. One transaction is
// accepted every clock unless the output stalls; there are 13 register stages:
// four stages form r2 (offsets, squares, the two halves of the scaling product,
// sum and clip), six stages take the square root at three bits each, and three
// stages form the products, the sum and the rounded, clipped gain. Registers
// must only be written while no transaction is in flight.
module radial_vignette_gain_top #(
	parameter int MAX_WIDTH  = rvg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rvg_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rvg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rvg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,  // column, row
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,  // gain
	output logic                            m_tuser   // saturated
);
	import rvg_pkg::*;

	cfg_t    cfg_q;
	radius_t rad_data;
	terms_t  terms_data;
	logic    rad_valid, rad_ready;
	logic    terms_valid, terms_ready;
	logic signed [GAIN_W-1:0] gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_CENTER_X:      cfg_q.center_x      <= cfg_data[15:0];
				REG_CENTER_Y:      cfg_q.center_y      <= cfg_data[15:0];
				REG_INV_RADIUS_SQ: cfg_q.inv_radius_sq <= cfg_data;
				REG_COEF_ROOT:     cfg_q.coef_root     <= cfg_data[COEF_W-1:0];
				REG_COEF_LINEAR:   cfg_q.coef_linear   <= cfg_data[COEF_W-1:0];
				REG_COEF_SQUARE:   cfg_q.coef_square   <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	rvg_radius #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.column   (s_tdata[11:0]),
		.row      (s_tdata[23:12]),
		.out_valid(rad_valid),
		.out_ready(rad_ready),
		.out_data (rad_data)
	);

	rvg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rad_valid),
		.in_ready (rad_ready),
		.in_data  (rad_data),
		.out_valid(terms_valid),
		.out_ready(terms_ready),
		.out_data (terms_data)
	);

	rvg_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (terms_valid),
		.in_ready (terms_ready),
		.in_data  (terms_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.gain     (gain),
		.saturated(m_tuser)
	);

	assign m_tdata = gain;

`ifndef SYNTH
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled although the output stage is empty");

	a_r2_clip: assert property (@(posedge clk) disable iff (!arst_n)
		rad_valid && rad_data.sat |-> rad_data.r2 == R2_MAX)
		else $error("clipped r2 is not the largest Q3.16 value");

	a_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		terms_valid && terms_data.r2 == '0 |-> terms_data.root == '0 &&
			terms_data.sq == '0)
		else $error("terms of a zero radius are not zero");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rvg_pkg::*;

	localparam int STALL_LIMIT       = 2000;
	localparam int PIPE_FLUSH_CYCLES = 16;
	localparam int HOLD_OFF_CYCLES   = 80;
	localparam int RANDOM_PHASES     = 10;
	localparam int ITEMS_PER_PHASE   = 55;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              sat;
	} gain_item_t;

	class gain_scoreboard;
		cfg_t       regs;
		gain_item_t expected_gains[$];
		int         mismatches;
		int         checked;
		int         clipped;

		function new();
			regs = '0;
			mismatches = 0;
			checked = 0;
			clipped = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CENTER_X:      regs.center_x = data[15:0];
				REG_CENTER_Y:      regs.center_y = data[15:0];
				REG_INV_RADIUS_SQ: regs.inv_radius_sq = data;
				REG_COEF_ROOT:     regs.coef_root = data[15:0];
				REG_COEF_LINEAR:   regs.coef_linear = data[15:0];
				REG_COEF_SQUARE:   regs.coef_square = data[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_gains.size();
		endfunction

		function gain_item_t predict_gain(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			gain_item_t   res;
			longint       a, b, c, dx, dy, acc, g;
			longint unsigned d2, r2, root, trial, sq;
			logic [65:0]  scaled;
			a = longint'($signed(regs.coef_root));
			b = longint'($signed(regs.coef_linear));
			c = longint'($signed(regs.coef_square));
			res.sat = 1'b0;
			if (a == 0 && b == 0 && c == 0) begin
				res.gain = GAIN_ONE;
				return res;
			end
			dx = longint'({col, 4'b0000}) - longint'(regs.center_x);
			dy = longint'({row, 4'b0000}) - longint'(regs.center_y);
			d2 = dx * dx + dy * dy;
			scaled = 66'(d2) * 66'(regs.inv_radius_sq);
			r2 = 64'(scaled[65:32]);
			if (r2 > R2_MAX) begin
				r2 = R2_MAX;
				res.sat = 1'b1;
			end
			root = 0;
			for (int k = ROOT_W - 1; k >= 0; k--) begin
				trial = root | (64'd1 << k);
				if (trial * trial <= (r2 << 16))
					root = trial;
			end
			sq = (r2 * r2) >> 16;
			acc = (longint'(1) << 28) + a * longint'(root) + b * longint'(r2)
				+ c * longint'(sq);
			g = (acc + 32768) >>> 16;
			if (g > 32767) begin
				g = 32767;
				res.sat = 1'b1;
			end else if (g < -32768) begin
				g = -32768;
				res.sat = 1'b1;
			end
			res.gain = g[15:0];
			return res;
		endfunction

		function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			expected_gains.push_back(predict_gain(col, row));
		endfunction

		task report(string msg);
			$display("%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [GAIN_W-1:0] gain, logic sat);
			gain_item_t want;
			if (expected_gains.size() == 0) begin
				report($sformatf("gain %0d arrived with nothing outstanding", $signed(gain)));
				return;
			end
			want = expected_gains.pop_front();
			checked++;
			if (want.sat)
				clipped++;
			if (gain !== want.gain)
				report($sformatf("gain %0d, expected %0d", $signed(gain), $signed(want.gain)));
			if (sat !== want.sat)
				report($sformatf("saturated flag %b, expected %b", sat, want.sat));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;  // column, row
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;  // gain
	logic                  m_tuser;  // saturated

	gain_scoreboard sb;
	bit send_steady;
	bit recv_steady;
	bit squeeze_pending;
	int pixels_sent;
	int settings_applied;

	radial_vignette_gain_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic apply_settings(input logic [15:0] cx, input logic [15:0] cy,
			input logic [31:0] inv, input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c);
		write_reg(REG_CENTER_X, {16'($urandom), cx});
		write_reg(REG_CENTER_Y, {16'($urandom), cy});
		write_reg(REG_INV_RADIUS_SQ, inv);
		write_reg(REG_COEF_ROOT, {16'($urandom), a});
		write_reg(REG_COEF_LINEAR, {16'($urandom), b});
		write_reg(REG_COEF_SQUARE, {16'($urandom), c});
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// Lowers the input, drains every outstanding result and lets the pipeline empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic pick_pace();
		send_steady = ($urandom_range(0, 3) == 0);
		recv_steady = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {row, col};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_pixel(col, row);
		pixels_sent++;
	endtask

	function automatic logic [COORD_W-1:0] draw_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
		return 12'($urandom_range(0, 4095));
	endfunction

	function automatic logic [15:0] draw_centre();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return 16'h0000;
		if (pick == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [31:0] draw_inv_radius();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 32'd0;
		if (pick == 1)
			return $urandom;
		if (pick == 2)
			return 32'hFFFF_FFFF;
		return $urandom_range(1 << 14, 1 << 19);
	endfunction

	function automatic logic [15:0] draw_coef();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return 16'h0000;
		if (pick == 1)
			return 16'($urandom);
		return 16'($urandom_range(0, 16383) - 8192);
	endfunction

	initial begin
		int squeeze_phase;
		sb = new();
		squeeze_phase = $urandom_range(0, RANDOM_PHASES - 1);
		pixels_sent = 0;
		settings_applied = 0;
		send_steady = 1'b0;
		recv_steady = 1'b0;
		squeeze_pending = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers still at their reset values: no coefficients, no radius.
		pick_pace();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);

		settle();
		apply_settings(16'd32768, 16'd32768, 32'd131072, 16'd2048, -16'sd1024, 16'd410);
		pick_pace();
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1000, 12'd3000);

		// Radius overflow: the largest inverse radius with the centre at the origin.
		settle();
		apply_settings(16'd0, 16'd0, 32'hFFFF_FFFF, -16'sd100, 16'd200, -16'sd50);
		pick_pace();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd0, 12'd1);
		send_pixel(12'd4095, 12'd4095);

		// Gain overflow upwards, centre at its largest value.
		settle();
		apply_settings(16'hFFFF, 16'hFFFF, 32'd262144, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		pick_pace();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);

		// Gain overflow downwards.
		settle();
		apply_settings(16'd32768, 16'd32768, 32'd131072, 16'h8000, 16'h8000, 16'h8000);
		pick_pace();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);

		// Zero inverse radius with live coefficients.
		settle();
		apply_settings(16'd100, 16'd65000, 32'd0, 16'd12345, -16'sd3000, 16'd7);
		pick_pace();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);

		// All coefficients zero although the radius would clip.
		settle();
		apply_settings(16'd0, 16'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
		pick_pace();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			apply_settings(draw_centre(), draw_centre(), draw_inv_radius(), draw_coef(),
				draw_coef(), draw_coef());
			pick_pace();
			if (p == squeeze_phase) begin
				send_steady = 1'b1;
				squeeze_pending = 1'b1;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_pixel(draw_coord(), draw_coord());
		end

		settle();
		$display("Run covered %0d pixels under %0d register settings.",
			pixels_sent, settings_applied);
		$display("%0d gains checked, %0d of them clipped.", sb.checked, sb.clipped);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		int hold;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_pending) begin
				hold = HOLD_OFF_CYCLES;
				squeeze_pending = 1'b0;
			end else begin
				hold = recv_steady ? 0 : $urandom_range(0, 18);
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_result(m_tdata, m_tuser);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rvg_pkg.sv
rtl/rvg_radius.sv
rtl/rvg_sqrt.sv
rtl/rvg_poly.sv
rtl/radial_vignette_gain_top.sv
dv/tb_top.sv
